// ===== sv/gtfr_pkg.sv =====
package gtfr_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;

    localparam int GLYPH_COLS   = 5;
    localparam int GLYPH_ROWS   = 7;
    localparam int ADVANCE      = 6;
    localparam int PAGES        = (SCREEN_HEIGHT + 7) / 8;
    localparam int FB_BYTES     = SCREEN_WIDTH * PAGES;
    localparam int ADDR_W       = $clog2(FB_BYTES);
    localparam int CUR_W        = $clog2(SCREEN_WIDTH + 1);
    localparam int FONT_ENTRIES = 36;
    localparam int FONT_IDX_W   = $clog2(FONT_ENTRIES);
    localparam int COL_W        = $clog2(GLYPH_COLS);
    localparam int DRAW_STEPS   = 2 * GLYPH_COLS;
    localparam int STEP_W       = $clog2(DRAW_STEPS + 1);
    localparam int CMDQ_DEPTH   = 2;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_DRAW  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [7:0] ASC_0      = 8'h30;
    localparam logic [7:0] ASC_9      = 8'h39;
    localparam logic [7:0] ASC_UA     = 8'h41;
    localparam logic [7:0] ASC_UZ     = 8'h5a;
    localparam logic [7:0] ASC_LA     = 8'h61;
    localparam logic [7:0] ASC_LZ     = 8'h7a;
    localparam logic [7:0] ASC_DOT    = 8'h2e;
    localparam logic [7:0] ASC_COLON  = 8'h3a;
    localparam logic [7:0] ASC_DASH   = 8'h2d;
    localparam logic [7:0] ASC_SLASH  = 8'h2f;
    localparam logic [7:0] CASE_FOLD  = 8'd32;
    localparam logic [7:0] LETTER_OFS = 8'd10;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_DRAW,
        OP_READ,
        OP_NOP
    } op_t;

    typedef logic [7:0]        byte_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // One classified request. For a draw, addr is the byte of the glyph's first
    // column in the page holding its top row; lo and hi are the bits to OR into
    // that page and the page below.
    typedef struct packed {
        op_t                        op;
        addr_t                      addr;
        logic                       rd_ok;
        byte_t [GLYPH_COLS-1:0]     lo;
        byte_t [GLYPH_COLS-1:0]     hi;
        logic                       drawn;
        logic [7:0]                 cursor_column;
    } cmd_t;

    // Digits first, then A to Z; bit 0 of each column is the top row.
    localparam logic [6:0] FONT_ROM [FONT_ENTRIES][GLYPH_COLS] = '{
        '{7'd62,  7'd81,  7'd73,  7'd69,  7'd62},
        '{7'd0,   7'd66,  7'd127, 7'd64,  7'd0},
        '{7'd66,  7'd97,  7'd81,  7'd73,  7'd70},
        '{7'd33,  7'd65,  7'd69,  7'd75,  7'd49},
        '{7'd24,  7'd20,  7'd18,  7'd127, 7'd16},
        '{7'd39,  7'd69,  7'd69,  7'd69,  7'd57},
        '{7'd60,  7'd74,  7'd73,  7'd73,  7'd48},
        '{7'd1,   7'd113, 7'd9,   7'd5,   7'd3},
        '{7'd54,  7'd73,  7'd73,  7'd73,  7'd54},
        '{7'd6,   7'd73,  7'd73,  7'd41,  7'd30},
        '{7'd126, 7'd17,  7'd17,  7'd17,  7'd126},
        '{7'd127, 7'd73,  7'd73,  7'd73,  7'd54},
        '{7'd62,  7'd65,  7'd65,  7'd65,  7'd34},
        '{7'd127, 7'd65,  7'd65,  7'd34,  7'd28},
        '{7'd127, 7'd73,  7'd73,  7'd73,  7'd65},
        '{7'd127, 7'd9,   7'd9,   7'd9,   7'd1},
        '{7'd62,  7'd65,  7'd73,  7'd73,  7'd122},
        '{7'd127, 7'd8,   7'd8,   7'd8,   7'd127},
        '{7'd0,   7'd65,  7'd127, 7'd65,  7'd0},
        '{7'd32,  7'd64,  7'd65,  7'd63,  7'd1},
        '{7'd127, 7'd8,   7'd20,  7'd34,  7'd65},
        '{7'd127, 7'd64,  7'd64,  7'd64,  7'd64},
        '{7'd127, 7'd2,   7'd12,  7'd2,   7'd127},
        '{7'd127, 7'd4,   7'd8,   7'd16,  7'd127},
        '{7'd62,  7'd65,  7'd65,  7'd65,  7'd62},
        '{7'd127, 7'd9,   7'd9,   7'd9,   7'd6},
        '{7'd62,  7'd65,  7'd81,  7'd33,  7'd94},
        '{7'd127, 7'd9,   7'd25,  7'd41,  7'd70},
        '{7'd70,  7'd73,  7'd73,  7'd73,  7'd49},
        '{7'd1,   7'd1,   7'd127, 7'd1,   7'd1},
        '{7'd63,  7'd64,  7'd64,  7'd64,  7'd63},
        '{7'd31,  7'd32,  7'd64,  7'd32,  7'd31},
        '{7'd63,  7'd64,  7'd56,  7'd64,  7'd63},
        '{7'd99,  7'd20,  7'd8,   7'd20,  7'd99},
        '{7'd7,   7'd8,   7'd112, 7'd8,   7'd7},
        '{7'd97,  7'd81,  7'd73,  7'd69,  7'd67}
    };

    function automatic logic [6:0] glyph_column(logic [7:0] code, logic [COL_W-1:0] col);
        logic [7:0] c;
        logic [6:0] g;
        c = code;
        g = '0;
        if (c >= ASC_LA && c <= ASC_LZ) begin
            c = c - CASE_FOLD;
        end
        if (c >= ASC_0 && c <= ASC_9) begin
            g = FONT_ROM[FONT_IDX_W'(c - ASC_0)][col];
        end else if (c >= ASC_UA && c <= ASC_UZ) begin
            g = FONT_ROM[FONT_IDX_W'(c - ASC_UA + LETTER_OFS)][col];
        end else if (c == ASC_DOT) begin
            g = (col == COL_W'(2)) ? 7'd64 : 7'd0;
        end else if (c == ASC_COLON) begin
            g = (col == COL_W'(2)) ? 7'd36 : 7'd0;
        end else if (c == ASC_DASH) begin
            g = 7'd8;
        end else if (c == ASC_SLASH) begin
            g = 7'd32 >> col;
        end
        return g;
    endfunction

endpackage

// ===== sv/gtfr_ram.sv =====
module gtfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/gtfr_front.sv =====
module gtfr_front
    import gtfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [1:0] func,
    input  logic [7:0] char_code,
    input  logic [5:0] top_row,
    input  logic       start_of_line,
    input  logic [9:0] byte_index,
    output cmd_t       cmd
);

    logic [CUR_W-1:0] cursor_reg;
    logic [CUR_W-1:0] cursor_next;
    logic [CUR_W-1:0] cur_sel;
    logic [CUR_W-1:0] cur_adv;
    logic             fits;
    logic [6:0]       row_mask;
    logic [6:0]       g;
    logic [14:0]      sh;
    int               base;

    always_comb
    begin
        cur_sel = start_of_line ? CUR_W'(1) : cursor_reg;
        fits    = (int'(cur_sel) + GLYPH_COLS) < SCREEN_WIDTH;
        cur_adv = cur_sel + CUR_W'(ADVANCE);

        cursor_next = cursor_reg;
        if (func == FUNC_DRAW)
        begin
            cursor_next = fits ? cur_adv : cur_sel;
        end

        // Glyph rows that fall below the screen are clipped here.
        for (int r = 0; r < GLYPH_ROWS; r++)
        begin
            row_mask[r] = (int'(top_row) + r) < SCREEN_HEIGHT;
        end

        cmd = '0;
        for (int c = 0; c < GLYPH_COLS; c++)
        begin
            g  = glyph_column(char_code, COL_W'(c)) & row_mask;
            sh = {8'b0, g} << top_row[2:0];
            cmd.lo[c] = fits ? sh[7:0] : 8'd0;
            cmd.hi[c] = fits ? {1'b0, sh[14:8]} : 8'd0;
        end

        base = int'(top_row[5:3]) * SCREEN_WIDTH + int'(cur_sel);
        cmd.rd_ok         = int'(byte_index) < FB_BYTES;
        cmd.cursor_column = 8'(cursor_next);
        cmd.drawn         = 1'b0;

        unique case (func)
            FUNC_CLEAR:
            begin
                cmd.op   = OP_CLEAR;
                cmd.addr = '0;
            end
            FUNC_DRAW:
            begin
                cmd.op    = fits ? OP_DRAW : OP_NOP;
                cmd.addr  = ADDR_W'(base);
                cmd.drawn = fits;
            end
            FUNC_READ:
            begin
                cmd.op   = OP_READ;
                cmd.addr = ADDR_W'(byte_index);
            end
            default:
            begin
                cmd.op   = OP_NOP;
                cmd.addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= CUR_W'(1);
        end
        else if (accept)
        begin
            cursor_reg <= cursor_next;
        end
    end

endmodule

// ===== sv/gtfr_cmd_fifo.sv =====
module gtfr_cmd_fifo
    import gtfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t din,
    output logic full,
    input  logic rd_en,
    output cmd_t dout,
    output logic empty
);

    localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    cmd_t             mem_reg [CMDQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = count_reg == CNT_W'(CMDQ_DEPTH);
    assign empty = count_reg == '0;
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/gtfr_engine.sv =====
module gtfr_engine
    import gtfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  logic       cmd_empty,
    output logic       cmd_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] read_data,
    output logic       drawn,
    output logic [7:0] cursor_column,
    output logic       init_busy
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_DRAW,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_FINISH
    } state_t;

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [STEP_W-1:0] step_reg;
    addr_t             sweep_reg;
    byte_t             res_data_reg;
    logic              out_valid_reg;
    byte_t             read_data_reg;
    logic              drawn_reg;
    logic [7:0]        cursor_column_reg;

    logic              ram_we;
    addr_t             ram_waddr;
    byte_t             ram_wdata;
    addr_t             ram_raddr;
    byte_t             ram_rdata;
    logic [STEP_W-1:0] prev_step;
    byte_t             prev_bits;
    logic              slot_free;

    // Even steps touch the glyph's upper page, odd steps the page below it.
    function automatic addr_t step_addr(addr_t base, logic [STEP_W-1:0] s);
        addr_t a;
        a = base + ADDR_W'(s[STEP_W-1:1]);
        if (s[0])
        begin
            a = a + ADDR_W'(SCREEN_WIDTH);
        end
        return a;
    endfunction

    function automatic byte_t step_bits(cmd_t c, logic [STEP_W-1:0] s);
        logic [COL_W-1:0] col;
        col = COL_W'(s[STEP_W-1:1]);
        return s[0] ? c.hi[col] : c.lo[col];
    endfunction

    gtfr_ram #(
        .WIDTH(8),
        .DEPTH(FB_BYTES)
    ) u_fb (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign slot_free = !out_valid_reg || pop;
    assign cmd_pop   = (state_reg == S_IDLE) && !cmd_empty;
    assign init_busy = state_reg == S_INIT;
    assign prev_step = step_reg - 1'b1;
    assign prev_bits = step_bits(cmd_reg, prev_step);

    // A draw is pipelined read-modify-write: the byte read in one step is
    // ORed and written back in the next, while the next byte is read.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = sweep_reg;
        ram_wdata = '0;
        ram_raddr = cmd_reg.addr;
        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                ram_we = 1'b1;
            end
            S_DRAW:
            begin
                ram_raddr = step_addr(cmd_reg.addr, step_reg);
                if (step_reg != '0)
                begin
                    ram_we    = prev_bits != '0;
                    ram_waddr = step_addr(cmd_reg.addr, prev_step);
                    ram_wdata = ram_rdata | prev_bits;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_INIT;
            cmd_reg           <= '0;
            sweep_reg         <= '0;
            step_reg          <= '0;
            res_data_reg      <= '0;
            out_valid_reg     <= 1'b0;
            read_data_reg     <= '0;
            drawn_reg         <= 1'b0;
            cursor_column_reg <= '0;
        end
        else
        begin
            // A beat loaded in the same cycle as a pop keeps the slot full.
            if (pop && state_reg != S_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT, S_CLEAR:
                begin
                    if (sweep_reg == ADDR_W'(FB_BYTES - 1))
                    begin
                        sweep_reg <= '0;
                        state_reg <= (state_reg == S_INIT) ? S_IDLE : S_FINISH;
                    end
                    else
                    begin
                        sweep_reg <= sweep_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (!cmd_empty)
                    begin
                        cmd_reg      <= cmd;
                        res_data_reg <= '0;
                        step_reg     <= '0;
                        unique case (cmd.op)
                            OP_CLEAR: state_reg <= S_CLEAR;
                            OP_DRAW:  state_reg <= S_DRAW;
                            OP_READ:  state_reg <= cmd.rd_ok ? S_RD_ISSUE : S_FINISH;
                            default:  state_reg <= S_FINISH;
                        endcase
                    end
                end
                S_DRAW:
                begin
                    if (step_reg == STEP_W'(DRAW_STEPS))
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_RD_ISSUE:
                begin
                    state_reg <= S_RD_WAIT;
                end
                S_RD_WAIT:
                begin
                    res_data_reg <= ram_rdata;
                    state_reg    <= S_FINISH;
                end
                S_FINISH:
                begin
                    out_valid_reg <= !slot_free || !pop ? out_valid_reg : 1'b0;
                    if (slot_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        read_data_reg     <= res_data_reg;
                        drawn_reg         <= cmd_reg.drawn;
                        cursor_column_reg <= cmd_reg.cursor_column;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign empty         = !out_valid_reg;
    assign read_data     = read_data_reg;
    assign drawn         = drawn_reg;
    assign cursor_column = cursor_column_reg;

endmodule

// ===== sv/glyph_text_framebuffer_renderer_top.sv =====
// Text renderer for a page-organized monochrome framebuffer with a built-in
// 5x7 font. Requests enter through a push/full queue port and each one gives
// exactly one result beat on the empty/pop side, in order. A small command
// queue separates request decoding (cursor, glyph lookup) from the framebuffer
// engine, so requests keep being taken while the engine works until that queue
// fills. The engine owns a single framebuffer RAM with one read and one write
// port, and those ports set the cost of each request: a draw runs dispatch, ten
// pipelined read-modify-write steps and completion, a read issues the address,
// waits for the RAM data and completes, a request with nothing to do goes
// straight to completion, and a clear sweeps one byte a cycle over all FB_BYTES
// bytes. After reset the same sweep runs with full held high until it is done.
module glyph_text_framebuffer_renderer_top
    import gtfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] func,
    input  logic [7:0] char_code,
    input  logic [5:0] top_row,
    input  logic       start_of_line,
    input  logic [9:0] byte_index,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] read_data,
    output logic       drawn,
    output logic [7:0] cursor_column
);

    cmd_t front_cmd;
    cmd_t q_cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic init_busy;
    logic accept;

    assign full   = q_full || init_busy;
    assign accept = push && !full;

    gtfr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .func         (func),
        .char_code    (char_code),
        .top_row      (top_row),
        .start_of_line(start_of_line),
        .byte_index   (byte_index),
        .cmd          (front_cmd)
    );

    gtfr_cmd_fifo u_cmdq (
        .clk  (clk),
        .rst_n(rst_n),
        .wr_en(accept),
        .din  (front_cmd),
        .full (q_full),
        .rd_en(q_pop),
        .dout (q_cmd),
        .empty(q_empty)
    );

    gtfr_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (q_cmd),
        .cmd_empty    (q_empty),
        .cmd_pop      (q_pop),
        .pop          (pop),
        .empty        (empty),
        .read_data    (read_data),
        .drawn        (drawn),
        .cursor_column(cursor_column),
        .init_busy    (init_busy)
    );

endmodule

// ===== dv/glyph_text_framebuffer_renderer_top_tb.sv =====
module glyph_text_framebuffer_renderer_top_tb;
    import gtfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB_COLS      = 128;
    localparam int FB_ROWS      = 64;
    localparam int FB_SIZE      = 1024;
    localparam int GLYPH_W      = 5;
    localparam int GLYPH_H      = 7;
    localparam int CURSOR_STEP  = 6;
    localparam int ITEM_TARGET  = 1150;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 40;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5a;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7a;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Columns of each glyph, digits then A to Z; bit 0 is the top row.
    localparam logic [6:0] GLYPH_ROM [36][5] = '{
        '{7'd62,  7'd81,  7'd73,  7'd69,  7'd62},
        '{7'd0,   7'd66,  7'd127, 7'd64,  7'd0},
        '{7'd66,  7'd97,  7'd81,  7'd73,  7'd70},
        '{7'd33,  7'd65,  7'd69,  7'd75,  7'd49},
        '{7'd24,  7'd20,  7'd18,  7'd127, 7'd16},
        '{7'd39,  7'd69,  7'd69,  7'd69,  7'd57},
        '{7'd60,  7'd74,  7'd73,  7'd73,  7'd48},
        '{7'd1,   7'd113, 7'd9,   7'd5,   7'd3},
        '{7'd54,  7'd73,  7'd73,  7'd73,  7'd54},
        '{7'd6,   7'd73,  7'd73,  7'd41,  7'd30},
        '{7'd126, 7'd17,  7'd17,  7'd17,  7'd126},
        '{7'd127, 7'd73,  7'd73,  7'd73,  7'd54},
        '{7'd62,  7'd65,  7'd65,  7'd65,  7'd34},
        '{7'd127, 7'd65,  7'd65,  7'd34,  7'd28},
        '{7'd127, 7'd73,  7'd73,  7'd73,  7'd65},
        '{7'd127, 7'd9,   7'd9,   7'd9,   7'd1},
        '{7'd62,  7'd65,  7'd73,  7'd73,  7'd122},
        '{7'd127, 7'd8,   7'd8,   7'd8,   7'd127},
        '{7'd0,   7'd65,  7'd127, 7'd65,  7'd0},
        '{7'd32,  7'd64,  7'd65,  7'd63,  7'd1},
        '{7'd127, 7'd8,   7'd20,  7'd34,  7'd65},
        '{7'd127, 7'd64,  7'd64,  7'd64,  7'd64},
        '{7'd127, 7'd2,   7'd12,  7'd2,   7'd127},
        '{7'd127, 7'd4,   7'd8,   7'd16,  7'd127},
        '{7'd62,  7'd65,  7'd65,  7'd65,  7'd62},
        '{7'd127, 7'd9,   7'd9,   7'd9,   7'd6},
        '{7'd62,  7'd65,  7'd81,  7'd33,  7'd94},
        '{7'd127, 7'd9,   7'd25,  7'd41,  7'd70},
        '{7'd70,  7'd73,  7'd73,  7'd73,  7'd49},
        '{7'd1,   7'd1,   7'd127, 7'd1,   7'd1},
        '{7'd63,  7'd64,  7'd64,  7'd64,  7'd63},
        '{7'd31,  7'd32,  7'd64,  7'd32,  7'd31},
        '{7'd63,  7'd64,  7'd56,  7'd64,  7'd63},
        '{7'd99,  7'd20,  7'd8,   7'd20,  7'd99},
        '{7'd7,   7'd8,   7'd112, 7'd8,   7'd7},
        '{7'd97,  7'd81,  7'd73,  7'd69,  7'd67}
    };

    typedef struct packed {
        logic [7:0] read_data;
        logic       drawn;
        logic [7:0] cursor_column;
    } reply_t;

    typedef enum logic [1:0] {
        POP_ALWAYS,
        POP_COIN,
        POP_PERIODIC,
        POP_SPARSE
    } pop_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [1:0] func = OP_NOP;
    logic [7:0] char_code = '0;
    logic [5:0] top_row = '0;
    logic       start_of_line = 1'b0;
    logic [9:0] byte_index = '0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] read_data;
    logic       drawn;
    logic [7:0] cursor_column;

    // Shadow copy of the display state, updated as each beat is accepted.
    logic [7:0] shadow_fb [FB_SIZE];
    int         shadow_cursor = 1;
    reply_t     predicted_replies [$];

    int n_errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_drawn = 0;
    int n_dropped = 0;
    int n_reads = 0;
    int n_lit_reads = 0;
    int n_clears = 0;
    int n_nops = 0;

    int  burst_left = 0;
    bit  sender_gaps_on = 1'b1;
    bit  hold_request = 1'b0;

    always #1 clk = ~clk;

    glyph_text_framebuffer_renderer_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .func          (func),
        .char_code     (char_code),
        .top_row       (top_row),
        .start_of_line (start_of_line),
        .byte_index    (byte_index),
        .empty         (empty),
        .pop           (pop),
        .read_data     (read_data),
        .drawn         (drawn),
        .cursor_column (cursor_column)
    );

    function automatic logic [6:0] glyph_bits(logic [7:0] code, int col);
        logic [7:0] ch;
        ch = code;
        if (ch >= CH_LA && ch <= CH_LZ) begin
            ch = ch - 8'd32;
        end
        if (ch >= CH_0 && ch <= CH_9) begin
            return GLYPH_ROM[ch - CH_0][col];
        end
        if (ch >= CH_UA && ch <= CH_UZ) begin
            return GLYPH_ROM[10 + (ch - CH_UA)][col];
        end
        if (ch == CH_DOT) begin
            return (col == 2) ? 7'd64 : 7'd0;
        end
        if (ch == CH_COLON) begin
            return (col == 2) ? 7'd36 : 7'd0;
        end
        if (ch == CH_DASH) begin
            return 7'd8;
        end
        if (ch == CH_SLASH) begin
            return 7'(32 >> col);
        end
        return 7'd0;
    endfunction

    function automatic reply_t apply_request(op_t op, logic [7:0] code, logic [5:0] top,
                                             logic sol, logic [9:0] idx);
        reply_t     rep;
        logic [6:0] bits;
        int         row;
        int         addr;
        rep = '0;
        case (op)
            OP_CLEAR: begin
                foreach (shadow_fb[i]) begin
                    shadow_fb[i] = '0;
                end
                n_clears++;
            end
            OP_DRAW: begin
                if (sol) begin
                    shadow_cursor = 1;
                end
                if (shadow_cursor + GLYPH_W < FB_COLS) begin
                    for (int c = 0; c < GLYPH_W; c++) begin
                        bits = glyph_bits(code, c);
                        for (int r = 0; r < GLYPH_H; r++) begin
                            row = top + r;
                            if (bits[r] && row < FB_ROWS) begin
                                addr = (row / 8) * FB_COLS + shadow_cursor + c;
                                shadow_fb[addr][row % 8] = 1'b1;
                            end
                        end
                    end
                    shadow_cursor += CURSOR_STEP;
                    rep.drawn = 1'b1;
                    n_drawn++;
                end else begin
                    n_dropped++;
                end
            end
            OP_READ: begin
                rep.read_data = shadow_fb[idx];
                n_reads++;
                if (rep.read_data != 0) begin
                    n_lit_reads++;
                end
            end
            default: begin
                n_nops++;
            end
        endcase
        rep.cursor_column = shadow_cursor[7:0];
        return rep;
    endfunction

    // Offers one beat and returns at the edge that takes it; the sender works
    // in bursts, with idle gaps between them while sender_gaps_on is set.
    task automatic send_item(op_t op, logic [7:0] code, logic [5:0] top, logic sol,
                             logic [9:0] idx);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (sender_gaps_on && gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        push          <= 1'b1;
        func          <= op;
        char_code     <= code;
        top_row       <= top;
        start_of_line <= sol;
        byte_index    <= idx;
        @(posedge clk);
        while (full !== 1'b0) begin
            @(posedge clk);
        end
        predicted_replies.push_back(apply_request(op, code, top, sol, idx));
        n_sent++;
        burst_left--;
    endtask

    task automatic drain_and_idle();
        push <= 1'b0;
        burst_left = 0;
        do begin
            @(posedge clk);
        end while (predicted_replies.size() != 0);
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 4))
            0: return CH_0 + 8'($urandom_range(0, 9));
            1: return CH_UA + 8'($urandom_range(0, 25));
            2: return CH_LA + 8'($urandom_range(0, 25));
            3: begin
                case ($urandom_range(0, 4))
                    0: return CH_DOT;
                    1: return CH_COLON;
                    2: return CH_DASH;
                    3: return CH_SLASH;
                    default: return CH_SPACE;
                endcase
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One line of text at a fixed row, long enough at times to run off the
    // right edge, followed by reads of the pages it touched.
    task automatic text_line();
        int         len;
        logic [5:0] top;
        logic       first_sol;
        int         page;
        len = $urandom_range(1, 24);
        top = 6'($urandom_range(0, 63));
        first_sol = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < len; i++) begin
            send_item(OP_DRAW, pick_char(), top,
                      (i == 0) ? first_sol : ($urandom_range(0, 15) == 0),
                      10'($urandom));
        end
        repeat ($urandom_range(1, 4)) begin
            page = top / 8 + $urandom_range(0, 1);
            if (page > 7) begin
                page = 7;
            end
            send_item(OP_READ, 8'($urandom), 6'($urandom), 1'($urandom),
                      10'(page * FB_COLS + $urandom_range(0, FB_COLS - 1)));
        end
    endtask

    task automatic test_reset_state();
        send_item(OP_READ, 8'h00, 6'd0, 1'b0, 10'd0);
        send_item(OP_READ, 8'hff, 6'd63, 1'b0, 10'd1023);
    endtask

    task automatic test_directed_glyphs();
        send_item(OP_DRAW, CH_0, 6'd0, 1'b1, 10'd0);
        // Lowercase folds to uppercase; at the last row most of it is clipped.
        send_item(OP_DRAW, CH_LA, 6'd63, 1'b0, 10'd1023);
        send_item(OP_DRAW, CH_UZ, 6'd5, 1'b0, 10'd0);
        send_item(OP_DRAW, CH_DOT, 6'd30, 1'b0, 10'd0);
        send_item(OP_DRAW, CH_COLON, 6'd40, 1'b0, 10'd0);
        send_item(OP_DRAW, CH_DASH, 6'd8, 1'b0, 10'd0);
        send_item(OP_DRAW, CH_SLASH, 6'd60, 1'b0, 10'd0);
        send_item(OP_DRAW, CH_SPACE, 6'd0, 1'b0, 10'd0);
        send_item(OP_DRAW, 8'hff, 6'd63, 1'b0, 10'd0);
        send_item(OP_DRAW, 8'h00, 6'd0, 1'b0, 10'd0);
        send_item(OP_DRAW, CH_9, 6'd58, 1'b0, 10'd0);
        send_item(OP_READ, 8'h00, 6'd0, 1'b0, 10'd13);
        send_item(OP_READ, 8'h00, 6'd0, 1'b1, 10'd141);
        send_item(OP_READ, 8'h00, 6'd0, 1'b0, 10'(7 * FB_COLS + 7));
        send_item(OP_NOP, 8'hff, 6'd63, 1'b1, 10'd1023);
        send_item(OP_DRAW, CH_UA + 8'd12, 6'd0, 1'b1, 10'd0);
        send_item(OP_READ, 8'h00, 6'd0, 1'b0, 10'd1);
        // Clear leaves the cursor where it was, start of line or not.
        send_item(OP_CLEAR, 8'hff, 6'd63, 1'b1, 10'd1023);
        send_item(OP_READ, 8'h00, 6'd0, 1'b0, 10'd1);
        send_item(OP_DRAW, CH_UA + 8'd22, 6'd63, 1'b0, 10'd0);
        send_item(OP_READ, 8'h00, 6'd0, 1'b0, 10'(7 * FB_COLS + 7));
    endtask

    task automatic test_receiver_holdoff();
        hold_request = 1'b1;
        sender_gaps_on = 1'b0;
        for (int i = 0; i < 16; i++) begin
            send_item(OP_DRAW, pick_char(), 6'd20, (i == 0), 10'($urandom));
        end
        repeat (8) begin
            send_item(OP_READ, 8'($urandom), 6'($urandom), 1'b0,
                      10'(2 * FB_COLS + $urandom_range(0, 127)));
        end
        sender_gaps_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        send_item(OP_DRAW, pick_char(), 6'd44, 1'b1, 10'd0);
        send_item(OP_DRAW, pick_char(), 6'd44, 1'b0, 10'd0);
        drain_and_idle();
        send_item(OP_READ, 8'h00, 6'd0, 1'b0, 10'(5 * FB_COLS + 3));
    endtask

    task automatic test_random_text();
        int pick;
        while (n_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                text_line();
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 8)) begin
                    send_item(OP_READ, 8'($urandom), 6'($urandom), 1'($urandom),
                              10'($urandom));
                end
            end else if (pick < 96) begin
                repeat ($urandom_range(1, 6)) begin
                    send_item(op_t'($urandom_range(1, 3)), 8'($urandom), 6'($urandom),
                              1'($urandom), 10'($urandom));
                end
            end else begin
                send_item(OP_CLEAR, 8'($urandom), 6'($urandom), 1'($urandom),
                          10'($urandom));
            end
        end
    endtask

    // Receiver: checks each popped beat and stalls on its own pattern.
    always @(posedge clk) begin
        static pop_mode_t pop_mode = POP_ALWAYS;
        static int        mode_left = 0;
        static int        hold_left = 0;
        static int        phase = 0;
        reply_t           want;
        if (rst_n === 1'b1 && pop === 1'b1 && empty === 1'b0) begin
            n_checked++;
            if (predicted_replies.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected beat: read_data %02h drawn %0b cursor_column %0d",
                         $time, read_data, drawn, cursor_column);
            end else begin
                want = predicted_replies.pop_front();
                if (read_data !== want.read_data) begin
                    n_errors++;
                    $display("%0t: read_data mismatch: expected %02h, actual %02h",
                             $time, want.read_data, read_data);
                end
                if (drawn !== want.drawn) begin
                    n_errors++;
                    $display("%0t: drawn mismatch: expected %0b, actual %0b",
                             $time, want.drawn, drawn);
                end
                if (cursor_column !== want.cursor_column) begin
                    n_errors++;
                    $display("%0t: cursor_column mismatch: expected %0d, actual %0d",
                             $time, want.cursor_column, cursor_column);
                end
            end
        end
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        phase++;
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                pop_mode = pop_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (pop_mode)
                POP_ALWAYS:   pop <= 1'b1;
                POP_COIN:     pop <= 1'($urandom_range(0, 1));
                POP_PERIODIC: pop <= (phase % 5 < 3);
                default:      pop <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Watchdog: ends the run if no beat moves on either side for too long.
    always @(posedge clk) begin
        static int quiet = 0;
        if ((push === 1'b1 && full === 1'b0) || (pop === 1'b1 && empty === 1'b0)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= STALL_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles, %0d results outstanding",
                     $time, quiet, predicted_replies.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        foreach (shadow_fb[i]) begin
            shadow_fb[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_directed_glyphs();
        test_receiver_holdoff();
        test_sender_pause();
        test_random_text();
        drain_and_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d requests, checked %0d results: %0d glyphs drawn, %0d dropped",
                 n_sent, n_checked, n_drawn, n_dropped);
        $display("%0d byte reads (%0d nonzero), %0d clears, %0d idle codes, %0d errors",
                 n_reads, n_lit_reads, n_clears, n_nops, n_errors);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/gtfr_pkg.sv
sv/gtfr_ram.sv
sv/gtfr_front.sv
sv/gtfr_cmd_fifo.sv
sv/gtfr_engine.sv
sv/glyph_text_framebuffer_renderer_top.sv
dv/glyph_text_framebuffer_renderer_top_tb.sv
